// ===== rtl/core/lctg_pkg.sv =====
// ----------------------------------------------------------------------------
// lctg_pkg
// Shared types, constants and helper functions of the chase trail generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lctg_pkg;

   localparam int unsigned MAX_LEDS_DEFAULT = 1024;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned COLOR_W  = 32;
   localparam int unsigned STRIP_W  = 11;
   localparam int unsigned IDX_W    = 10;
   localparam int unsigned DELAY_W  = 10;
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned TRAIL_W  = 4;
   localparam int unsigned POS_W    = 16;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [DELAY_W-1:0] DELAY_BASE = 10'd20;
   localparam logic [CHAN_W-1:0]  CHAN_FULL  = 8'hFF;
   localparam logic [TRAIL_W-1:0] TRAIL_BASE = 4'd2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_SPEED     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTENSITY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HAS_WHITE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STRIP_LEN = 3'd4;

   typedef struct packed {
      logic [CHAN_W-1:0]  speed;
      logic [CHAN_W-1:0]  intensity;
      logic [COLOR_W-1:0] primary_color;
      logic               has_white;
      logic [STRIP_W-1:0] strip_length;
   } cfg_type;

   typedef struct packed {
      logic load_div;   // load time word, divide by frame delay
      logic div_step;   // one restoring divide step
      logic load_mod;   // reload with 16-bit quotient, divide by strip length
      logic init_pix;   // start trail walk at the head position
      logic emit;       // drive one pixel word and advance
   } cmd_type;

   typedef struct packed {
      logic last;       // current pixel is the final one of the frame
   } status_type;

   // 255 / trail for trail lengths 2..9
   function automatic logic [CHAN_W-1:0] trail_step(input logic [TRAIL_W-1:0] trail);
      logic [CHAN_W-1:0] s;
      case (trail)
         4'd2:    s = 8'd127;
         4'd3:    s = 8'd85;
         4'd4:    s = 8'd63;
         4'd5:    s = 8'd51;
         4'd6:    s = 8'd42;
         4'd7:    s = 8'd36;
         4'd8:    s = 8'd31;
         4'd9:    s = 8'd28;
         default: s = 8'd0;
      endcase
      return s;
   endfunction

   // (c * b) / 255, exact over the 16-bit product range
   function automatic logic [CHAN_W-1:0] scale_channel(input logic [CHAN_W-1:0] c,
                                                       input logic [CHAN_W-1:0] b);
      logic [15:0] prod;
      logic [16:0] sum;
      prod = c * b;
      sum  = 17'(prod) + 17'd1 + 17'(prod[15:8]);
      return sum[15:8];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lctg_csr.sv =====
// ----------------------------------------------------------------------------
// lctg_csr
// Configuration registers, written through the csr valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lctg_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               busy,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [lctg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [31:0]                        csr_data,
   output lctg_pkg::cfg_type                       cfg
);

   lctg_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;

   // hold off writes while a frame is in flight
   assign csr_ready = !busy;
   assign wr_en     = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index)
            lctg_pkg::REG_SPEED:     cfg_in.speed         = csr_data[7:0];
            lctg_pkg::REG_INTENSITY: cfg_in.intensity     = csr_data[7:0];
            lctg_pkg::REG_COLOR:     cfg_in.primary_color = csr_data;
            lctg_pkg::REG_HAS_WHITE: cfg_in.has_white     = csr_data[0];
            lctg_pkg::REG_STRIP_LEN: cfg_in.strip_length  = csr_data[10:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed         <= 8'd128;
         cfg_ff.intensity     <= 8'd128;
         cfg_ff.primary_color <= 32'h00FF_0000;
         cfg_ff.has_white     <= 1'b0;
         cfg_ff.strip_length  <= 11'd60;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lctg_ctrl.sv =====
// ----------------------------------------------------------------------------
// lctg_ctrl
// Frame sequencer: divide by delay, reduce modulo length, emit trail pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module lctg_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire lctg_pkg::status_type status,
   output lctg_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_LOADM = 3'd2;
   localparam logic [2:0] ST_MOD   = 3'd3;
   localparam logic [2:0] ST_INIT  = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   localparam logic [4:0] DIV_LAST = 5'(lctg_pkg::TIME_W - 1);
   localparam logic [4:0] MOD_LAST = 5'(lctg_pkg::POS_W - 1);

   logic [2:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_div = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_LOADM;
            end
         end
         ST_LOADM: begin
            cmd.load_mod = 1'b1;
            cnt_in       = '0;
            state_in     = ST_MOD;
         end
         ST_MOD: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == MOD_LAST) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init_pix = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/lctg_datapath.sv =====
// ----------------------------------------------------------------------------
// lctg_datapath
// Shared restoring divider, trail walker and color fade, with result word.
// ----------------------------------------------------------------------------
`default_nettype none

module lctg_datapath #(
   parameter int unsigned MAX_LEDS = lctg_pkg::MAX_LEDS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lctg_pkg::cfg_type                 cfg,
   input  wire lctg_pkg::cmd_type                 cmd,
   output lctg_pkg::status_type                   status,
   input  wire logic [lctg_pkg::TIME_W-1:0]       req_time_ms,
   output logic                                   rsp_valid,
   output logic [lctg_pkg::IDX_W-1:0]             rsp_led_index,
   output logic [lctg_pkg::COLOR_W-1:0]           rsp_pixel_color,
   output logic [lctg_pkg::DELAY_W-1:0]           rsp_frame_delay,
   output logic                                   rsp_last_pixel
);

   localparam int unsigned STRIP_MAX = (1 << lctg_pkg::STRIP_W) - 1;
   localparam int unsigned CAP_INT   = (MAX_LEDS < STRIP_MAX) ? MAX_LEDS : STRIP_MAX;
   localparam logic [lctg_pkg::STRIP_W-1:0] LEN_CAP = lctg_pkg::STRIP_W'(CAP_INT);

   localparam int unsigned SW = lctg_pkg::STRIP_W;
   localparam int unsigned TW = lctg_pkg::TIME_W;
   localparam int unsigned CW = lctg_pkg::CHAN_W;

   // derived frame settings
   logic [lctg_pkg::DELAY_W-1:0] delay;
   logic [SW-1:0]                len;
   logic [lctg_pkg::TRAIL_W-1:0] trail;
   logic [CW-1:0]                step;

   assign delay = (lctg_pkg::DELAY_W'(lctg_pkg::CHAN_FULL - cfg.speed) << 1)
                  + lctg_pkg::DELAY_BASE;
   assign trail = lctg_pkg::TRAIL_BASE + lctg_pkg::TRAIL_W'(cfg.intensity[7:5]);
   assign step  = lctg_pkg::trail_step(trail);

   always_comb begin
      if (cfg.strip_length == '0) begin
         len = SW'(1);
      end else if (cfg.strip_length > LEN_CAP) begin
         len = LEN_CAP;
      end else begin
         len = cfg.strip_length;
      end
   end

   // divider: quotient bits shift into the low end of dvd_ff
   logic [TW-1:0] dvd_ff, dvd_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic          sel_len_ff, sel_len_in;
   logic [SW-1:0] divisor;
   logic [SW:0]   trial;
   logic [SW:0]   diff;
   logic          fits;

   assign divisor = sel_len_ff ? len : SW'(delay);
   assign trial   = {rem_ff, dvd_ff[TW-1]};
   assign diff    = trial - {1'b0, divisor};
   assign fits    = (trial >= {1'b0, divisor});

   // trail walker
   logic [SW-1:0]                idx_ff, idx_in;
   logic [CW-1:0]                bright_ff, bright_in;
   logic [lctg_pkg::TRAIL_W-1:0] pix_ff, pix_in;
   logic                         last;

   assign last        = (pix_ff == trail - lctg_pkg::TRAIL_W'(1));
   assign status.last = last;

   // faded color of the current pixel
   logic [CW-1:0] w_ch, r_ch, g_ch, b_ch;

   assign w_ch = cfg.has_white
                 ? lctg_pkg::scale_channel(cfg.primary_color[31:24], bright_ff) : '0;
   assign r_ch = lctg_pkg::scale_channel(cfg.primary_color[23:16], bright_ff);
   assign g_ch = lctg_pkg::scale_channel(cfg.primary_color[15:8], bright_ff);
   assign b_ch = lctg_pkg::scale_channel(cfg.primary_color[7:0], bright_ff);

   // result word
   logic                         valid_ff;
   logic [lctg_pkg::IDX_W-1:0]   led_ff;
   logic [lctg_pkg::COLOR_W-1:0] color_ff;
   logic [lctg_pkg::DELAY_W-1:0] delay_ff;
   logic                         lastp_ff;

   always_comb begin
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      sel_len_in = sel_len_ff;
      idx_in     = idx_ff;
      bright_in  = bright_ff;
      pix_in     = pix_ff;
      if (cmd.load_div) begin
         dvd_in     = req_time_ms;
         rem_in     = '0;
         sel_len_in = 1'b0;
      end else if (cmd.load_mod) begin
         // low 16 quotient bits go to the top so they enter first
         dvd_in     = {dvd_ff[lctg_pkg::POS_W-1:0], {(TW-lctg_pkg::POS_W){1'b0}}};
         rem_in     = '0;
         sel_len_in = 1'b1;
      end else if (cmd.div_step) begin
         dvd_in = {dvd_ff[TW-2:0], fits};
         rem_in = fits ? diff[SW-1:0] : trial[SW-1:0];
      end
      if (cmd.init_pix) begin
         idx_in    = rem_ff;
         bright_in = lctg_pkg::CHAN_FULL;
         pix_in    = '0;
      end else if (cmd.emit) begin
         // step back one LED, wrapping to the far end
         idx_in    = (idx_ff == '0) ? (len - SW'(1)) : (idx_ff - SW'(1));
         bright_in = bright_ff - step;
         pix_in    = pix_ff + lctg_pkg::TRAIL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      idx_ff    <= idx_in;
      bright_ff <= bright_in;
      pix_ff    <= pix_in;
      if (cmd.emit) begin
         led_ff   <= idx_ff[lctg_pkg::IDX_W-1:0];
         color_ff <= {w_ch, r_ch, g_ch, b_ch};
         delay_ff <= delay;
         lastp_ff <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         sel_len_ff <= 1'b0;
      end else begin
         valid_ff   <= cmd.emit;
         sel_len_ff <= sel_len_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_led_index   = led_ff;
   assign rsp_pixel_color = color_ff;
   assign rsp_frame_delay = delay_ff;
   assign rsp_last_pixel  = lastp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/led_chase_trail_generator_top.sv =====
// ----------------------------------------------------------------------------
// led_chase_trail_generator_top
// Chase effect with a fading trail: one frame request in, trail pixels out.
// ----------------------------------------------------------------------------
// A frame request is taken when start is high and busy is low. The block
// divides the time by the frame delay and reduces the 16-bit quotient modulo
// the strip length on one shared bit-serial divider (32 + 16 steps), then
// emits one pixel word per cycle, head first, 2 to 9 words per frame. The
// block takes the next request at the edge that ends the last word of a
// frame. Each word is on the rsp_ ports for one cycle only, marked by
// rsp_valid; the receiver cannot stall it and must take it then.
// Configuration writes are held off (csr_ready low) while busy.
// ----------------------------------------------------------------------------
`default_nettype none

module led_chase_trail_generator_top #(
   parameter int unsigned MAX_LEDS = lctg_pkg::MAX_LEDS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [lctg_pkg::TIME_W-1:0]        req_time_ms,
   output logic                                    rsp_valid,
   output logic [lctg_pkg::IDX_W-1:0]              rsp_led_index,
   output logic [lctg_pkg::COLOR_W-1:0]            rsp_pixel_color,
   output logic [lctg_pkg::DELAY_W-1:0]            rsp_frame_delay,
   output logic                                    rsp_last_pixel,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [lctg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [31:0]                        csr_data
);

   lctg_pkg::cfg_type    cfg;
   lctg_pkg::cmd_type    cmd;
   lctg_pkg::status_type status;

   lctg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .busy      (busy),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lctg_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   lctg_datapath #(
      .MAX_LEDS (MAX_LEDS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .req_time_ms     (req_time_ms),
      .rsp_valid       (rsp_valid),
      .rsp_led_index   (rsp_led_index),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_frame_delay (rsp_frame_delay),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule

`default_nettype wire

// ===== test/led_chase_trail_generator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_chase_trail_generator_top_tb
// Self-checking bench for the chase trail generator.
// A directed table walks the register extremes, the strip length wrap,
// zero and oversized lengths and the 16-bit position truncation. Random
// frames under random register settings follow. Every trail word is
// checked against a local prediction, with random gaps on the request side.
// ----------------------------------------------------------------------------

module led_chase_trail_generator_top_tb;

   localparam logic [lctg_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int unsigned STRIP_CAP   = lctg_pkg::MAX_LEDS_DEFAULT;
   localparam int unsigned QUIET_LIMIT = 1000;
   localparam int unsigned TAIL_CYCLES = 64;
   localparam int unsigned PHASES      = 10;
   localparam int unsigned PHASE_ITEMS = 29;

   typedef struct packed {
      logic [lctg_pkg::IDX_W-1:0]   led;
      logic [lctg_pkg::COLOR_W-1:0] color;
      logic [lctg_pkg::DELAY_W-1:0] delay;
      logic                         last;
   } pixel_type;

   typedef enum logic {ROW_WRITE, ROW_FRAME} row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [lctg_pkg::CSR_IDX_W-1:0] index;
      logic [31:0]                    data;
      logic                           has_head;
      pixel_type                      head;
   } row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic [lctg_pkg::TIME_W-1:0]    req_time_ms = '0;
   logic                           rsp_valid;
   logic [lctg_pkg::IDX_W-1:0]     rsp_led_index;
   logic [lctg_pkg::COLOR_W-1:0]   rsp_pixel_color;
   logic [lctg_pkg::DELAY_W-1:0]   rsp_frame_delay;
   logic                           rsp_last_pixel;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [lctg_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]                    csr_data = '0;

   // register shadow, reset values
   logic [7:0]                   speed_r     = 8'd128;
   logic [7:0]                   intensity_r = 8'd128;
   logic [lctg_pkg::COLOR_W-1:0] color_r     = 32'h00FF0000;
   logic                         white_r     = 1'b0;
   logic [lctg_pkg::STRIP_W-1:0] strip_r     = 11'd60;

   pixel_type   pixels_due[$];
   row_type     dir_rows[$];
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;
   pixel_type   due_pixel;
   pixel_type   seen_pixel;
   logic        took_word;

   always #5 clock = ~clock;

   led_chase_trail_generator_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_time_ms     (req_time_ms),
      .rsp_valid       (rsp_valid),
      .rsp_led_index   (rsp_led_index),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_frame_delay (rsp_frame_delay),
      .rsp_last_pixel  (rsp_last_pixel),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   function automatic row_type frame_row(input logic [31:0] t);
      return {ROW_FRAME, 3'd0, t, 1'b0, 53'd0};
   endfunction

   function automatic row_type head_row(input logic [31:0] t, input pixel_type head);
      return {ROW_FRAME, 3'd0, t, 1'b1, head};
   endfunction

   function automatic row_type write_row(input logic [lctg_pkg::CSR_IDX_W-1:0] idx,
                                         input logic [31:0] d);
      return {ROW_WRITE, idx, d, 1'b0, 53'd0};
   endfunction

   function automatic logic [7:0] dim(input logic [7:0] c, input int unsigned b);
      int unsigned p;
      p = (c * b) / 255;
      return p[7:0];
   endfunction

   // Queue the trail words of one frame, head first.
   task automatic forecast_trail(input logic [31:0] t, input logic typed,
                                 input pixel_type head);
      int unsigned delay, span, trail, fade_step, pos, back, idx, bright, k;
      pixel_type   px;
      delay = 20 + 2 * (255 - speed_r);
      span = (strip_r == 0) ? 1 : ((strip_r > STRIP_CAP) ? STRIP_CAP : strip_r);
      trail = 2 + intensity_r / 32;
      fade_step = 255 / trail;
      pos = ((t / delay) & 32'hFFFF) % span;
      for (k = 0; k < trail; k++) begin
         back = k % span;
         idx = (pos >= back) ? pos - back : pos + span - back;
         bright = 255 - k * fade_step;
         px.led = idx[lctg_pkg::IDX_W-1:0];
         px.color[31:24] = white_r ? dim(color_r[31:24], bright) : 8'd0;
         px.color[23:16] = dim(color_r[23:16], bright);
         px.color[15:8] = dim(color_r[15:8], bright);
         px.color[7:0] = dim(color_r[7:0], bright);
         px.delay = delay[lctg_pkg::DELAY_W-1:0];
         px.last = (k + 1 == trail);
         if (k == 0 && typed) begin
            px = head;
         end
         pixels_due.push_back(px);
      end
   endtask

   // Idle for gap cycles once the block is free, then raise the request.
   task automatic send_frame(input logic [31:0] t, input logic typed, input pixel_type head,
                             input int unsigned gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         while (busy) @(negedge clock);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_time_ms <= t;
      do @(posedge clock); while (busy);
      forecast_trail(t, typed, head);
   endtask

   // Drop start and wait until every trail word has come back.
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [lctg_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] d);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         lctg_pkg::REG_SPEED:     speed_r = d[7:0];
         lctg_pkg::REG_INTENSITY: intensity_r = d[7:0];
         lctg_pkg::REG_COLOR:     color_r = d;
         lctg_pkg::REG_HAS_WHITE: white_r = d[0];
         lctg_pkg::REG_STRIP_LEN: strip_r = d[lctg_pkg::STRIP_W-1:0];
         default:                 ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic shuffle_regs();
      logic [31:0] d;
      int unsigned pick;
      settle();
      if ($urandom_range(0, 1)) begin
         d = $urandom;
         pick = $urandom_range(0, 3);
         if (pick == 0) d[7:0] = 8'd0;
         if (pick == 1) d[7:0] = 8'd255;
         write_reg(lctg_pkg::REG_SPEED, d);
      end
      if ($urandom_range(0, 1)) begin
         write_reg(lctg_pkg::REG_INTENSITY, $urandom);
      end
      if ($urandom_range(0, 1)) begin
         pick = $urandom_range(0, 5);
         d = (pick == 0) ? 32'h0 : ((pick == 1) ? 32'hFFFFFFFF : $urandom);
         write_reg(lctg_pkg::REG_COLOR, d);
      end
      if ($urandom_range(0, 1)) begin
         write_reg(lctg_pkg::REG_HAS_WHITE, $urandom);
      end
      if ($urandom_range(0, 1)) begin
         d = $urandom;
         case ($urandom_range(0, 7))
            0:       d[10:0] = 11'd0;
            1:       d[10:0] = 11'd1024;
            2:       d[10:0] = 11'($urandom_range(1025, 2047));
            3:       d[10:0] = 11'd1;
            4, 5:    d[10:0] = 11'($urandom_range(2, 16));
            default: d[10:0] = 11'($urandom_range(1, 1024));
         endcase
         write_reg(lctg_pkg::REG_STRIP_LEN, d);
      end
   endtask

   task automatic flag_field(input string field, input logic [31:0] want, input logic [31:0] got);
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         took_word = 1'b0;
         if (rsp_valid) begin
            seen_pixel = {rsp_led_index, rsp_pixel_color, rsp_frame_delay, rsp_last_pixel};
            if (pixels_due.size() == 0) begin
               $display("%0t: unexpected word, expected none actual %h", $time, seen_pixel);
               mismatch_count++;
            end else begin
               took_word = 1'b1;
               due_pixel = pixels_due.pop_front();
               if (seen_pixel.led !== due_pixel.led)
                  flag_field("led_index", due_pixel.led, seen_pixel.led);
               if (seen_pixel.color !== due_pixel.color)
                  flag_field("pixel_color", due_pixel.color, seen_pixel.color);
               if (seen_pixel.delay !== due_pixel.delay)
                  flag_field("frame_delay", due_pixel.delay, seen_pixel.delay);
               if (seen_pixel.last !== due_pixel.last)
                  flag_field("last_pixel", due_pixel.last, seen_pixel.last);
            end
         end
         if ((start && !busy) || took_word || (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int unsigned r, phase, n, gap;
      logic        calm;
      logic [31:0] t;

      // reset values: delay 274, trail 6, red only
      dir_rows.push_back(head_row(32'd0, {10'd0, 32'h00FF0000, 10'd274, 1'b0}));
      dir_rows.push_back(frame_row(32'hFFFFFFFF));
      // quotient of exactly 65536 truncates to position zero
      dir_rows.push_back(head_row(32'd17956864, {10'd0, 32'h00FF0000, 10'd274, 1'b0}));
      dir_rows.push_back(write_row(lctg_pkg::REG_SPEED, 32'hFFFFFFFF));
      dir_rows.push_back(write_row(lctg_pkg::REG_INTENSITY, 32'hFFFFFF00));
      dir_rows.push_back(write_row(lctg_pkg::REG_STRIP_LEN, 32'd1));
      // trail of two on a one-LED strip
      dir_rows.push_back(head_row(32'd0, {10'd0, 32'h00FF0000, 10'd20, 1'b0}));
      dir_rows.push_back(frame_row(32'd7777));
      dir_rows.push_back(write_row(lctg_pkg::REG_STRIP_LEN, 32'hFFFFF800));
      dir_rows.push_back(frame_row(32'd12345));
      dir_rows.push_back(write_row(lctg_pkg::REG_STRIP_LEN, 32'hFFFFFFFF));
      dir_rows.push_back(frame_row(32'hFFFFFFFF));
      dir_rows.push_back(write_row(REG_UNUSED, 32'hFFFFFFFF));
      dir_rows.push_back(frame_row(32'd99999));
      dir_rows.push_back(write_row(lctg_pkg::REG_SPEED, 32'h0));
      dir_rows.push_back(write_row(lctg_pkg::REG_INTENSITY, 32'd255));
      dir_rows.push_back(write_row(lctg_pkg::REG_COLOR, 32'hFFFFFFFF));
      dir_rows.push_back(write_row(lctg_pkg::REG_HAS_WHITE, 32'hFFFFFFFF));
      dir_rows.push_back(write_row(lctg_pkg::REG_STRIP_LEN, 32'd1024));
      dir_rows.push_back(head_row(32'd0, {10'd0, 32'hFFFFFFFF, 10'd530, 1'b0}));
      // head near zero, tail wraps to the top of the strip
      dir_rows.push_back(frame_row(32'd2650));
      dir_rows.push_back(frame_row(32'hFFFFFFFF));
      dir_rows.push_back(write_row(lctg_pkg::REG_HAS_WHITE, 32'hFFFFFFFE));
      dir_rows.push_back(frame_row(32'd1000));
      dir_rows.push_back(write_row(lctg_pkg::REG_STRIP_LEN, 32'd9));
      dir_rows.push_back(frame_row(32'd2120));
      dir_rows.push_back(write_row(lctg_pkg::REG_STRIP_LEN, 32'd3));
      dir_rows.push_back(write_row(lctg_pkg::REG_INTENSITY, 32'd96));
      dir_rows.push_back(frame_row(32'd123456));
      dir_rows.push_back(write_row(lctg_pkg::REG_COLOR, 32'h80402010));
      dir_rows.push_back(write_row(lctg_pkg::REG_INTENSITY, 32'd31));
      dir_rows.push_back(write_row(lctg_pkg::REG_SPEED, 32'd200));
      dir_rows.push_back(frame_row(32'd55555));
      dir_rows.push_back(write_row(lctg_pkg::REG_INTENSITY, 32'd224));
      dir_rows.push_back(write_row(lctg_pkg::REG_STRIP_LEN, 32'd1025));
      dir_rows.push_back(write_row(lctg_pkg::REG_COLOR, 32'h01010101));
      dir_rows.push_back(write_row(lctg_pkg::REG_HAS_WHITE, 32'd1));
      dir_rows.push_back(frame_row(32'hFFFF0000));
      dir_rows.push_back(write_row(lctg_pkg::REG_COLOR, 32'h0));
      dir_rows.push_back(frame_row(32'd314159));
      dir_rows.push_back(frame_row(32'h80000000));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < dir_rows.size(); r++) begin
         if (dir_rows[r].kind == ROW_WRITE) begin
            settle();
            write_reg(dir_rows[r].index, dir_rows[r].data);
         end else begin
            send_frame(dir_rows[r].data, dir_rows[r].has_head, dir_rows[r].head,
                       $urandom_range(0, 13));
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         shuffle_regs();
         // hold some phases with back-to-back requests
         calm = ($urandom_range(0, 3) == 0);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200000) : $urandom;
            gap = calm ? 0 : $urandom_range(0, 13);
            send_frame(t, 1'b0, '0, gap);
         end
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
